// ===== design/scaled_glyph_framebuffer_renderer_defines.svh =====
// Assertion macros used by the checker file of the glyph renderer.
`ifndef SCALED_GLYPH_FRAMEBUFFER_RENDERER_DEFINES_SVH
`define SCALED_GLYPH_FRAMEBUFFER_RENDERER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sgfr_pkg.sv =====
// Types, constants and the font ROM of the scaled glyph renderer.
`default_nettype none

package sgfr_pkg;

    localparam int CW      = 12;
    localparam int COUNT_W = 15;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_FILL  = 2'd1,
        REQ_CHAR  = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_GLYPH  = 6'b000010,
        ST_PAINT  = 6'b000100,
        ST_READ   = 6'b001000,
        ST_RDATA  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // Row 0 is the top row; bit 4 of each row is the leftmost column.
    typedef logic [0:6][4:0] glyph_t;

    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        glyph_t g;
        unique case (code)
            8'h2B: g = {5'h00, 5'h04, 5'h04, 5'h1f, 5'h04, 5'h04, 5'h00};
            8'h2D: g = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            8'h30: g = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            8'h31: g = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            8'h32: g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            8'h33: g = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
            8'h34: g = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            8'h35: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
            8'h36: g = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            8'h37: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: g = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            8'h39: g = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
            8'h41: g = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            8'h42: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            8'h44: g = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
            8'h49: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
            8'h4D: g = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4F: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            8'h50: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            8'h52: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            8'h53: g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            8'h54: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            // The space and every unknown code draw as the blank glyph.
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== design/scaled_glyph_framebuffer_renderer.sv =====
// Top level of the scaled glyph renderer: frame store, painter and result register.
//
// Requests arrive on the s_axis channel, one transfer per request; the request
// kind travels in s_axis_tuser. Each request gives exactly one result transfer
// on the m_axis channel. The frame store is one single-port synchronous RAM of
// SCREEN_WIDTH*SCREEN_HEIGHT entries, and every write goes through that one
// port, one pixel per cycle, so work is set by the number of pixels written:
//   clear         all SCREEN_WIDTH*SCREEN_HEIGHT entries
//   fill          the clipped area (none when empty)
//   character     the clipped square of each set cell of the 35 glyph cells
//   read          none; ST_READ then ST_RDATA fetch the entry
// One request is worked on at a time; s_axis_tready is high only while idle.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits; a stalled receiver holds the block only when a
// second result is ready to be loaded.
// After reset the block sweeps the whole store to zero, one entry per cycle,
// and accepts no request until done.
`default_nettype none

module scaled_glyph_framebuffer_renderer
    import sgfr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 160
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x_pos[9:0], y_pos[19:10], rect_width[27:20], rect_height[35:28],
    // char_code[43:36], scale_factor[47:44], pixel_color[63:48]
    input  wire logic [63:0] s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_color[15:0], out_of_range[16], pixels_written[31:17]
    output logic [31:0]      m_axis_tdata
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam int XEW   = $clog2(SCREEN_WIDTH + 1);
    localparam int YEW   = $clog2(SCREEN_HEIGHT + 1);
    localparam logic signed [CW-1:0] W_S = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] H_S = CW'(SCREEN_HEIGHT);

    logic [15:0] mem [DEPTH];
    logic [15:0] mem_q;

    state_t state_reg, state_next;
    logic init_reg, init_next;
    logic is_glyph_reg, is_glyph_next;
    logic glyph_end_reg, glyph_end_next;
    logic [XW-1:0]  col_reg, col_next;
    logic [YW-1:0]  row_reg, row_next;
    logic [XW-1:0]  x0_reg, x0_next;
    logic [XEW-1:0] x1_reg, x1_next;
    logic [YEW-1:0] y1_reg, y1_next;
    logic [15:0]    color_reg, color_next;
    glyph_t         glyph_reg, glyph_next;
    logic signed [CW-1:0] gx_reg, gx_next;
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;
    logic [3:0]     scale_reg, scale_next;
    logic [2:0]     cell_row_reg, cell_row_next;
    logic [2:0]     cell_col_reg, cell_col_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]    rd_color_reg, rd_color_next;
    logic           oor_reg, oor_next;
    logic           out_valid_reg, out_valid_next;
    logic [31:0]    out_data_reg, out_data_next;

    logic [9:0]  in_x;
    logic [9:0]  in_y;
    logic [7:0]  in_w;
    logic [7:0]  in_h;
    logic [7:0]  in_code;
    logic [3:0]  in_scale;
    logic [15:0] in_color;
    req_t        in_req;

    logic signed [CW-1:0] bx, by, bw, bh, ex, ey, cx0, cx1, cy0, cy1;
    logic clip_empty;
    logic [AW-1:0] pix_addr;
    logic col_last, row_last;
    logic cell_bit, cell_last;
    logic signed [CW-1:0] scale_ext;

    assign in_x     = s_axis_tdata[9:0];
    assign in_y     = s_axis_tdata[19:10];
    assign in_w     = s_axis_tdata[27:20];
    assign in_h     = s_axis_tdata[35:28];
    assign in_code  = s_axis_tdata[43:36];
    assign in_scale = s_axis_tdata[47:44];
    assign in_color = s_axis_tdata[63:48];
    assign in_req   = req_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign scale_ext = {{(CW-4){1'b0}}, scale_reg};

    // One clipping unit, shared by rectangle fills and glyph squares.
    always_comb
    begin
        if (state_reg == ST_GLYPH)
        begin
            bx = cx_reg;
            by = cy_reg;
            bw = scale_ext;
            bh = scale_ext;
        end
        else
        begin
            bx = {{(CW-10){in_x[9]}}, in_x};
            by = {{(CW-10){in_y[9]}}, in_y};
            bw = {{(CW-8){1'b0}}, in_w};
            bh = {{(CW-8){1'b0}}, in_h};
        end
        ex  = bx + bw;
        ey  = by + bh;
        cx0 = bx[CW-1] ? '0 : bx;
        cy0 = by[CW-1] ? '0 : by;
        cx1 = (ex > W_S) ? W_S : ex;
        cy1 = (ey > H_S) ? H_S : ey;
        clip_empty = (cx0 >= cx1) || (cy0 >= cy1);
    end

    assign pix_addr = AW'(row_reg) * AW'(SCREEN_WIDTH) + AW'(col_reg);
    assign col_last = ((XEW'(col_reg) + XEW'(1)) == x1_reg);
    assign row_last = ((YEW'(row_reg) + YEW'(1)) == y1_reg);
    assign cell_bit = glyph_reg[cell_row_reg][3'd4 - cell_col_reg];
    assign cell_last = (cell_row_reg == 3'd6) && (cell_col_reg == 3'd4);

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        is_glyph_next  = is_glyph_reg;
        glyph_end_next = glyph_end_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        x0_next        = x0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        color_next     = color_reg;
        glyph_next     = glyph_reg;
        gx_next        = gx_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        scale_next     = scale_reg;
        cell_row_next  = cell_row_reg;
        cell_col_next  = cell_col_reg;
        cnt_next       = cnt_reg;
        rd_color_next  = rd_color_reg;
        oor_next       = oor_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cnt_next      = '0;
                    rd_color_next = '0;
                    oor_next      = 1'b0;
                    is_glyph_next = 1'b0;
                    color_next    = in_color;
                    unique case (in_req)
                        REQ_CLEAR:
                        begin
                            color_next = '0;
                            col_next   = '0;
                            row_next   = '0;
                            x0_next    = '0;
                            x1_next    = XEW'(SCREEN_WIDTH);
                            y1_next    = YEW'(SCREEN_HEIGHT);
                            state_next = ST_PAINT;
                        end
                        REQ_FILL:
                        begin
                            col_next = cx0[XW-1:0];
                            row_next = cy0[YW-1:0];
                            x0_next  = cx0[XW-1:0];
                            x1_next  = cx1[XEW-1:0];
                            y1_next  = cy1[YEW-1:0];
                            state_next = clip_empty ? ST_FINISH : ST_PAINT;
                        end
                        REQ_CHAR:
                        begin
                            glyph_next    = glyph_lookup(in_code);
                            gx_next       = bx;
                            cx_next       = bx;
                            cy_next       = by;
                            scale_next    = in_scale;
                            cell_row_next = '0;
                            cell_col_next = '0;
                            is_glyph_next = 1'b1;
                            state_next    = ST_GLYPH;
                        end
                        REQ_READ:
                        begin
                            col_next = bx[XW-1:0];
                            row_next = by[YW-1:0];
                            if (bx < 0 || bx >= W_S || by < 0 || by >= H_S)
                            begin
                                oor_next   = 1'b1;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_GLYPH:
            begin
                if (cell_col_reg == 3'd4)
                begin
                    cell_col_next = '0;
                    cell_row_next = cell_row_reg + 3'd1;
                    cx_next       = gx_reg;
                    cy_next       = cy_reg + scale_ext;
                end
                else
                begin
                    cell_col_next = cell_col_reg + 3'd1;
                    cx_next       = cx_reg + scale_ext;
                end
                if (cell_bit && !clip_empty)
                begin
                    col_next       = cx0[XW-1:0];
                    row_next       = cy0[YW-1:0];
                    x0_next        = cx0[XW-1:0];
                    x1_next        = cx1[XEW-1:0];
                    y1_next        = cy1[YEW-1:0];
                    glyph_end_next = cell_last;
                    state_next     = ST_PAINT;
                end
                else if (cell_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PAINT:
            begin
                cnt_next = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + COUNT_W'(1);
                if (col_last)
                begin
                    col_next = x0_reg;
                    row_next = row_reg + YW'(1);
                    if (row_last)
                    begin
                        priority if (init_reg)
                        begin
                            init_next  = 1'b0;
                            state_next = ST_IDLE;
                        end
                        else if (is_glyph_reg && !glyph_end_reg)
                        begin
                            state_next = ST_GLYPH;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
                else
                begin
                    col_next = col_reg + XW'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_RDATA;
            end
            ST_RDATA:
            begin
                rd_color_next = mem_q;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {cnt_reg, oor_reg, rd_color_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PAINT;
            init_reg      <= 1'b1;
            is_glyph_reg  <= 1'b0;
            glyph_end_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            x0_reg        <= '0;
            x1_reg        <= XEW'(SCREEN_WIDTH);
            y1_reg        <= YEW'(SCREEN_HEIGHT);
            color_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            is_glyph_reg  <= is_glyph_next;
            glyph_end_reg <= glyph_end_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            x0_reg        <= x0_next;
            x1_reg        <= x1_next;
            y1_reg        <= y1_next;
            color_reg     <= color_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        glyph_reg    <= glyph_next;
        gx_reg       <= gx_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        scale_reg    <= scale_next;
        cell_row_reg <= cell_row_next;
        cell_col_reg <= cell_col_next;
        rd_color_reg <= rd_color_next;
        oor_reg      <= oor_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PAINT)
        begin
            mem[pix_addr] <= color_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            mem_q <= mem[pix_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/sgfr_checker.sv =====
// Port-level checker of the scaled glyph renderer and its bind statement.
`default_nettype none
`include "scaled_glyph_framebuffer_renderer_defines.svh"

module sgfr_checker
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 160
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;

    // A held result keeps its contents until the transfer completes.
    `SGFR_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // Every accepted request takes the block out of idle in the cycle after it.
    `SGFR_ASSERT_NXT(a_busy_after_req, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted on consecutive cycles")

    // An off-screen read returns neither a color nor a write count.
    `SGFR_ASSERT_IMP(a_oor_clean, clk, rst_n, m_axis_tvalid && m_axis_tdata[16], (m_axis_tdata[15:0] == 16'd0) && (m_axis_tdata[31:17] == 15'd0), "out-of-range result carries data")

    // No request writes more entries than the store holds.
    `SGFR_ASSERT_IMP(a_count_bound, clk, rst_n, m_axis_tvalid, 32'(m_axis_tdata[31:17]) <= 32'(DEPTH), "write count exceeds store size")

endmodule

bind scaled_glyph_framebuffer_renderer sgfr_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_sgfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/scaled_glyph_framebuffer_renderer_tb.sv =====
// Self-checking testbench for the scaled glyph frame store renderer.
`timescale 1ns / 100ps

module scaled_glyph_framebuffer_renderer_tb;

    import sgfr_pkg::*;

    localparam int SCREEN_W   = 128;
    localparam int SCREEN_H   = 160;
    localparam int IDLE_LIMIT = 100000;
    localparam int PRINT_CAP  = 100;
    localparam logic [8*23-1:0] FONT_CODES = " +-0123456789ABDIMOPRST";

    typedef struct packed {
        logic [15:0] color;
        logic [3:0]  scale;
        logic [7:0]  code;
        logic [7:0]  h;
        logic [7:0]  w;
        logic [9:0]  y;
        logic [9:0]  x;
    } draw_fields_t;

    typedef struct packed {
        logic [14:0] pixels_written;
        logic        out_of_range;
        logic [15:0] read_color;
    } render_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    logic [15:0]    fb_shadow [0:SCREEN_W*SCREEN_H-1];
    render_result_t render_reports [$];
    render_result_t got_report;
    render_result_t want_report;
    int             error_count;
    int             burst_left;
    int             idle_cycles;
    int             sent_count [4];
    int             offscreen_reads;
    longint         pixels_total;
    int             last_x;
    int             last_y;

    scaled_glyph_framebuffer_renderer #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    function automatic logic [34:0] glyph_bits(input logic [7:0] code);
        case (code)
            8'h2B: return {5'h00, 5'h04, 5'h04, 5'h1f, 5'h04, 5'h04, 5'h00};
            8'h2D: return {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            8'h30: return {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            8'h31: return {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            8'h32: return {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            8'h33: return {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
            8'h34: return {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            8'h35: return {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
            8'h36: return {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            8'h37: return {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            8'h38: return {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            8'h39: return {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
            8'h41: return {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            8'h42: return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            8'h44: return {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
            8'h49: return {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1f};
            8'h4D: return {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            8'h4F: return {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            8'h50: return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            8'h52: return {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            8'h53: return {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            8'h54: return {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            default: return '0;
        endcase
    endfunction

    function automatic int paint_rect(input int x, input int y, input int w, input int h,
                                      input logic [15:0] color);
        int x0;
        int y0;
        int x1;
        int y1;
        int r;
        int c;
        int n;
        x0 = (x < 0) ? 0 : x;
        y0 = (y < 0) ? 0 : y;
        x1 = (x + w > SCREEN_W) ? SCREEN_W : x + w;
        y1 = (y + h > SCREEN_H) ? SCREEN_H : y + h;
        n  = 0;
        for (r = y0; r < y1; r++) begin
            for (c = x0; c < x1; c++) begin
                fb_shadow[r*SCREEN_W + c] = color;
                n++;
            end
        end
        return n;
    endfunction

    function automatic render_result_t apply_render_request(input req_t kind,
                                                            input draw_fields_t f);
        render_result_t res;
        logic [34:0]    rows;
        int             x;
        int             y;
        int             s;
        int             count;
        int             r;
        int             c;
        res   = '0;
        x     = int'($signed(f.x));
        y     = int'($signed(f.y));
        s     = int'(f.scale);
        count = 0;
        case (kind)
            REQ_CLEAR:
            begin
                for (r = 0; r < SCREEN_W*SCREEN_H; r++)
                begin
                    fb_shadow[r] = '0;
                end
                count = SCREEN_W*SCREEN_H;
            end
            REQ_FILL:
            begin
                count = paint_rect(x, y, int'(f.w), int'(f.h), f.color);
            end
            REQ_CHAR:
            begin
                rows = glyph_bits(f.code);
                for (r = 0; r < 7; r++)
                begin
                    for (c = 0; c < 5; c++)
                    begin
                        if (rows[34 - 5*r - c])
                        begin
                            count += paint_rect(x + c*s, y + r*s, s, s, f.color);
                        end
                    end
                end
            end
            default:
            begin
                if (x < 0 || x >= SCREEN_W || y < 0 || y >= SCREEN_H)
                begin
                    res.out_of_range = 1'b1;
                    offscreen_reads++;
                end
                else
                begin
                    res.read_color = fb_shadow[y*SCREEN_W + x];
                end
            end
        endcase
        pixels_total += count;
        if (count > 32767)
        begin
            count = 32767;
        end
        res.pixels_written = 15'(count);
        return res;
    endfunction

    function automatic draw_fields_t fields(input int x, input int y, input int w, input int h,
                                            input int code, input int scale, input int color);
        draw_fields_t f;
        f.x     = x[9:0];
        f.y     = y[9:0];
        f.w     = w[7:0];
        f.h     = h[7:0];
        f.code  = code[7:0];
        f.scale = scale[3:0];
        f.color = color[15:0];
        return f;
    endfunction

    task automatic send_request(input req_t kind, input draw_fields_t f);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        render_reports.push_back(apply_render_request(kind, f));
        sent_count[int'(kind)]++;
    endtask

    task automatic test_reset_state();
        send_request(REQ_READ, fields(0, 0, 0, 0, 0, 0, 0));
        send_request(REQ_READ, fields(SCREEN_W-1, SCREEN_H-1, 255, 255, 255, 15, 'hFFFF));
        send_request(REQ_READ, fields(-1, 0, 0, 0, 0, 0, 0));
        send_request(REQ_READ, fields(0, SCREEN_H, 0, 0, 0, 0, 0));
        send_request(REQ_READ, fields(511, -512, 0, 0, 0, 0, 0));
    endtask

    task automatic test_fill_clipping();
        send_request(REQ_FILL, fields(-512, -512, 255, 255, 0, 0, 'hABCD));
        send_request(REQ_FILL, fields(-10, -10, 255, 255, 0, 0, 'hFFFF));
        send_request(REQ_READ, fields(SCREEN_W-1, SCREEN_H-1, 0, 0, 0, 0, 0));
        send_request(REQ_FILL, fields(5, 5, 0, 10, 0, 0, 'h5555));
        send_request(REQ_FILL, fields(5, 5, 10, 0, 0, 0, 'h5555));
        send_request(REQ_FILL, fields(120, 150, 20, 20, 0, 0, 'h1234));
        send_request(REQ_READ, fields(SCREEN_W-1, SCREEN_H-1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_glyph_drawing();
        send_request(REQ_CHAR, fields(0, 0, 0, 0, 'h41, 1, 'hF800));
        send_request(REQ_READ, fields(1, 0, 0, 0, 0, 0, 0));
        send_request(REQ_CHAR, fields(100, 140, 0, 0, 'h30, 8, 'h07E0));
        send_request(REQ_CHAR, fields(20, 20, 0, 0, 'hFF, 2, 'h001F));
        send_request(REQ_CHAR, fields(20, 20, 0, 0, 'h20, 3, 'h001F));
        send_request(REQ_CHAR, fields(20, 20, 0, 0, 'h4D, 0, 'h001F));
        send_request(REQ_CHAR, fields(-20, -20, 0, 0, 'h54, 15, 'h0F0F));
    endtask

    task automatic test_clear_and_read();
        send_request(REQ_CLEAR, fields(0, 0, 0, 0, 0, 0, 0));
        send_request(REQ_READ, fields(SCREEN_W-1, SCREEN_H-1, 0, 0, 0, 0, 0));
        send_request(REQ_READ, fields(1, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_mix(input int n_items);
        draw_fields_t f;
        req_t         kind;
        int           pick;
        int           i;
        for (i = 0; i < n_items; i++)
        begin
            f    = {$urandom, $urandom};
            pick = $urandom_range(0, 999);
            if (pick < 3)
            begin
                kind = REQ_CLEAR;
            end
            else if (pick < 300)
            begin
                kind = REQ_FILL;
                if ($urandom_range(0, 4) != 0)
                begin
                    f.x = 10'($urandom_range(0, 151) - 16);
                    f.y = 10'($urandom_range(0, 183) - 16);
                end
                if ($urandom_range(0, 24) != 0)
                begin
                    f.w = 8'($urandom_range(0, 40));
                    f.h = 8'($urandom_range(0, 40));
                end
                last_x = int'($signed(f.x));
                last_y = int'($signed(f.y));
            end
            else if (pick < 650)
            begin
                kind = REQ_CHAR;
                if ($urandom_range(0, 4) != 0)
                begin
                    f.code = FONT_CODES[8*$urandom_range(0, 22) +: 8];
                end
                pick = $urandom_range(0, 19);
                if (pick < 17)
                begin
                    f.scale = 4'($urandom_range(1, 3));
                end
                else if (pick < 19)
                begin
                    f.scale = 4'($urandom_range(4, 8));
                end
                else
                begin
                    f.scale = 4'($urandom_range(0, 15));
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    f.x = 10'($urandom_range(0, 150) - 20);
                    f.y = 10'($urandom_range(0, 185) - 20);
                end
                last_x = int'($signed(f.x));
                last_y = int'($signed(f.y));
            end
            else
            begin
                kind = REQ_READ;
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    f.x = 10'(last_x + $urandom_range(0, 40));
                    f.y = 10'(last_y + $urandom_range(0, 56));
                end
                else if (pick < 9)
                begin
                    f.x = 10'($urandom_range(0, SCREEN_W-1));
                    f.y = 10'($urandom_range(0, SCREEN_H-1));
                end
            end
            send_request(kind, f);
        end
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        if (error_count < PRINT_CAP)
        begin
            $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
        end
        error_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_report = m_axis_tdata;
            if (render_reports.size() == 0)
            begin
                report_mismatch("unexpected result, expected none", 0, int'(got_report));
            end
            else
            begin
                want_report = render_reports.pop_front();
                if (got_report.read_color !== want_report.read_color)
                begin
                    report_mismatch("read_color", int'(want_report.read_color),
                                    int'(got_report.read_color));
                end
                if (got_report.out_of_range !== want_report.out_of_range)
                begin
                    report_mismatch("out_of_range", int'(want_report.out_of_range),
                                    int'(got_report.out_of_range));
                end
                if (got_report.pixels_written !== want_report.pixels_written)
                begin
                    report_mismatch("pixels_written", int'(want_report.pixels_written),
                                    int'(got_report.pixels_written));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, render_reports.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int mode;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 300))
            begin
                @(negedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 1) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = REQ_CLEAR;
        error_count     = 0;
        burst_left      = 0;
        idle_cycles     = 0;
        offscreen_reads = 0;
        pixels_total    = 0;
        last_x          = 0;
        last_y          = 0;
        sent_count      = '{0, 0, 0, 0};
        for (int i = 0; i < SCREEN_W*SCREEN_H; i++)
        begin
            fb_shadow[i] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_fill_clipping();
        test_glyph_drawing();
        test_clear_and_read();
        test_random_mix(1830);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (render_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("Covered %0d clears, %0d fills, %0d characters and %0d reads (%0d off screen).",
                 sent_count[REQ_CLEAR], sent_count[REQ_FILL], sent_count[REQ_CHAR],
                 sent_count[REQ_READ], offscreen_reads);
        $display("Frame store writes tracked: %0d pixels; mismatches: %0d.",
                 pixels_total, error_count);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/sgfr_pkg.sv
design/scaled_glyph_framebuffer_renderer.sv
design/sgfr_checker.sv
bench/scaled_glyph_framebuffer_renderer_tb.sv
